[sv/hpd_pkg.sv]
// package for the hold-and-modify pixel decoder: payload types, tables, constants
`default_nettype none
package hpd_pkg;

	localparam int PaletteDepth = 64;
	localparam int PixelsPerGroup = 8;
	localparam int PalIdxW = $clog2(PaletteDepth);
	localparam int CountW = 4;
	localparam int LaneIdxW = $clog2(PixelsPerGroup);
	localparam logic [7:0] AlphaOn = 8'd255;

	typedef enum logic [1:0] {
		MOD_LOAD  = 2'd0,
		MOD_BLUE  = 2'd1,
		MOD_RED   = 2'd2,
		MOD_GREEN = 2'd3
	} mod_t;

	typedef enum logic {
		OP_PAL_WRITE = 1'b0,
		OP_DECODE    = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_HAM8  = 1'b0,
		REG_ALPHA = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic        op;
		logic [5:0]  palette_index;
		logic [23:0] palette_color;
		logic [63:0] plane_bytes;
		logic [3:0]  pixel_count;
		logic        line_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} out_item_t;

	// what one lane found for one pixel
	typedef struct packed {
		mod_t        mode;
		logic [5:0]  data;
		logic [7:0]  comp;
	} lane_res_t;

	function automatic logic [7:0] lut4(input logic [3:0] d);
		return {d, d};
	endfunction

	function automatic logic [7:0] lut6(input logic [5:0] d);
		logic [7:0] r;
		case (d)
			6'd0: r = 8'd0;     6'd1: r = 8'd4;     6'd2: r = 8'd8;     6'd3: r = 8'd12;
			6'd4: r = 8'd16;    6'd5: r = 8'd20;    6'd6: r = 8'd24;    6'd7: r = 8'd28;
			6'd8: r = 8'd32;    6'd9: r = 8'd36;    6'd10: r = 8'd40;   6'd11: r = 8'd44;
			6'd12: r = 8'd48;   6'd13: r = 8'd52;   6'd14: r = 8'd56;   6'd15: r = 8'd60;
			6'd16: r = 8'd64;   6'd17: r = 8'd68;   6'd18: r = 8'd72;   6'd19: r = 8'd76;
			6'd20: r = 8'd80;   6'd21: r = 8'd85;   6'd22: r = 8'd89;   6'd23: r = 8'd93;
			6'd24: r = 8'd97;   6'd25: r = 8'd101;  6'd26: r = 8'd105;  6'd27: r = 8'd109;
			6'd28: r = 8'd113;  6'd29: r = 8'd117;  6'd30: r = 8'd121;  6'd31: r = 8'd125;
			6'd32: r = 8'd129;  6'd33: r = 8'd133;  6'd34: r = 8'd137;  6'd35: r = 8'd141;
			6'd36: r = 8'd145;  6'd37: r = 8'd149;  6'd38: r = 8'd153;  6'd39: r = 8'd157;
			6'd40: r = 8'd161;  6'd41: r = 8'd165;  6'd42: r = 8'd170;  6'd43: r = 8'd174;
			6'd44: r = 8'd178;  6'd45: r = 8'd182;  6'd46: r = 8'd186;  6'd47: r = 8'd190;
			6'd48: r = 8'd194;  6'd49: r = 8'd198;  6'd50: r = 8'd202;  6'd51: r = 8'd206;
			6'd52: r = 8'd210;  6'd53: r = 8'd214;  6'd54: r = 8'd218;  6'd55: r = 8'd222;
			6'd56: r = 8'd226;  6'd57: r = 8'd230;  6'd58: r = 8'd234;  6'd59: r = 8'd238;
			6'd60: r = 8'd242;  6'd61: r = 8'd246;  6'd62: r = 8'd250;  default: r = 8'd255;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/ham_pixel_decoder.sv]
// top level of the hold-and-modify pixel decoder
// A palette write transaction gives no output. A decode transaction gives pixel_count
// pixels (capped at 8), one per cycle unless the output stalls, and holds off the next
// transaction until its last pixel is emitted; the eight lanes decode a group in the
// cycle it is accepted and a serial merge stage applies the hold colour chain one pixel a
// cycle while the output buffer has room. The palette is read through a registered port
// one pixel ahead of the merge, and entry 0 is mirrored in a register for the line start
// reload. A two-entry output buffer lets the chain continue while the consumer stalls.
// Palette entries read before being written return arbitrary colours.
`default_nettype none
module ham_pixel_decoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire hpd_pkg::in_item_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output hpd_pkg::out_item_t       out_data,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [0:0]          cfg_data
);
	logic ham8_q, alpha_q;
	logic [23:0] pal_q [hpd_pkg::PaletteDepth];
	logic [23:0] pal_rd_q;
	logic [23:0] entry0_q;
	logic [23:0] hold_q;

	hpd_pkg::lane_res_t lane_res [hpd_pkg::PixelsPerGroup];
	hpd_pkg::lane_res_t grp_s1 [hpd_pkg::PixelsPerGroup];
	logic [hpd_pkg::CountW-1:0] left_s1;
	logic [hpd_pkg::LaneIdxW-1:0] pos_s1;
	logic busy_s1;

	// output buffer
	hpd_pkg::out_item_t buf_q [2];
	logic [1:0] fill_q;
	logic rd_q, wr_q;

	logic accept, emit, pop, dec_acc;
	logic [hpd_pkg::CountW-1:0] cnt;
	logic [hpd_pkg::PalIdxW-1:0] rd_addr;
	hpd_pkg::lane_res_t cur;
	logic [23:0] nxt, base;

	for (genvar i = 0; i < hpd_pkg::PixelsPerGroup; i++) begin : g_lane
		hpd_lane u_lane (
			.plane_bytes(in_data.plane_bytes),
			.bitpos(3'(7 - i)),
			.ham8(ham8_q),
			.res(lane_res[i])
		);
	end

	assign pop = out_valid && !out_stall;
	// emit only while the buffer has a free entry or one is popped in the same cycle
	assign emit = busy_s1 && (fill_q != 2'd2 || pop);
	assign in_stall = busy_s1 && !(emit && left_s1 == 4'd1);
	assign accept = in_valid && !in_stall;
	assign dec_acc = accept && in_data.op == hpd_pkg::OP_DECODE;
	assign cnt = (in_data.pixel_count > 4'd8) ? 4'd8 : in_data.pixel_count;
	// palette lookahead: first pixel of a new group, else the next pixel of this one
	assign rd_addr = dec_acc ? lane_res[0].data : grp_s1[pos_s1 + 3'd1].data;

	always_comb begin
		cur = grp_s1[pos_s1];
		base = hold_q;
		case (cur.mode)
			hpd_pkg::MOD_LOAD: nxt = pal_rd_q;
			hpd_pkg::MOD_BLUE: nxt = {base[23:8], cur.comp};
			hpd_pkg::MOD_RED: nxt = {cur.comp, base[15:0]};
			default: nxt = {base[23:16], cur.comp, base[7:0]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.op == hpd_pkg::OP_PAL_WRITE) begin
			pal_q[in_data.palette_index] <= in_data.palette_color;
			if (in_data.palette_index == '0) entry0_q <= in_data.palette_color;
		end
		if (dec_acc || emit) begin
			pal_rd_q <= pal_q[rd_addr];
		end
		if (dec_acc) begin
			for (int i = 0; i < hpd_pkg::PixelsPerGroup; i++) grp_s1[i] <= lane_res[i];
		end
		if (emit) begin
			buf_q[wr_q] <= '{red: nxt[23:16], green: nxt[15:8], blue: nxt[7:0],
				alpha: alpha_q ? hpd_pkg::AlphaOn : 8'd0, last: left_s1 == 4'd1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ham8_q <= 1'b0;
			alpha_q <= 1'b0;
			hold_q <= '0;
			busy_s1 <= 1'b0;
			left_s1 <= '0;
			pos_s1 <= '0;
			fill_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == hpd_pkg::REG_HAM8) ham8_q <= cfg_data[0];
				else alpha_q <= cfg_data[0];
			end
			if (emit) begin
				hold_q <= nxt;
				left_s1 <= left_s1 - 4'd1;
				pos_s1 <= pos_s1 + 3'd1;
				if (left_s1 == 4'd1) busy_s1 <= 1'b0;
				wr_q <= ~wr_q;
			end
			if (dec_acc) begin
				if (in_data.line_start) hold_q <= entry0_q;
				left_s1 <= cnt;
				pos_s1 <= '0;
				busy_s1 <= cnt != 4'd0;
			end
			if (pop) rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, emit} - {1'b0, pop};
		end
	end

	assign out_valid = fill_q != 2'd0;
	assign out_data = buf_q[rd_q];
endmodule
`default_nettype wire

[sv/hpd_lane.sv]
// one decode lane: gathers a pixel code from the planes and expands its data bits
`default_nettype none
module hpd_lane (
	input  wire logic [63:0]        plane_bytes,
	input  wire logic [2:0]         bitpos,
	input  wire logic               ham8,
	output hpd_pkg::lane_res_t      res
);
	logic [7:0] code;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			code[k] = plane_bytes[8*k + int'(bitpos)];
		end
		if (ham8) begin
			res.mode = hpd_pkg::mod_t'(code[7:6]);
			res.data = code[5:0];
			res.comp = hpd_pkg::lut6(code[5:0]);
		end else begin
			res.mode = hpd_pkg::mod_t'(code[5:4]);
			res.data = {2'b00, code[3:0]};
			res.comp = hpd_pkg::lut4(code[3:0]);
		end
	end
endmodule
`default_nettype wire

[verif/ham_pixel_decoder_tb.sv]
// testbench for the hold-and-modify pixel decoder: random and directed decode with a scoreboard
`timescale 1ns / 100ps
`default_nettype none

module ham_pixel_decoder_tb;

	class pixel_scoreboard;
		logic [23:0] palette [hpd_pkg::PaletteDepth];
		logic [23:0] hold;
		bit ham8;
		bit alpha_on;
		hpd_pkg::out_item_t pending_pixels[$];
		int errors;

		function void reset_state();
			hold = '0;
			ham8 = 0;
			alpha_on = 0;
			errors = 0;
			foreach (palette[i]) palette[i] = '0;
		endfunction

		function logic [7:0] expand(logic [5:0] d);
			if (ham8) return hpd_pkg::lut6(d);
			return hpd_pkg::lut4(d[3:0]);
		endfunction

		function void note_input(hpd_pkg::in_item_t it);
			int n;
			int nplanes;
			logic [7:0] code;
			logic [5:0] d;
			logic [1:0] m;
			logic [7:0] c;
			hpd_pkg::out_item_t o;
			if (it.op == hpd_pkg::OP_PAL_WRITE) begin
				palette[it.palette_index] = it.palette_color;
				return;
			end
			if (it.line_start) hold = palette[0];
			n = (it.pixel_count > hpd_pkg::PixelsPerGroup) ? hpd_pkg::PixelsPerGroup
				: it.pixel_count;
			nplanes = ham8 ? 8 : 6;
			for (int i = 0; i < n; i++) begin
				code = '0;
				for (int k = 0; k < nplanes; k++) code[k] = it.plane_bytes[8 * k + 7 - i];
				if (ham8) begin
					m = code[7:6];
					d = code[5:0];
				end else begin
					m = code[5:4];
					d = {2'b00, code[3:0]};
				end
				c = expand(d);
				case (hpd_pkg::mod_t'(m))
					hpd_pkg::MOD_LOAD: hold = palette[d];
					hpd_pkg::MOD_BLUE: hold[7:0] = c;
					hpd_pkg::MOD_RED: hold[23:16] = c;
					default: hold[15:8] = c;
				endcase
				o.red = hold[23:16];
				o.green = hold[15:8];
				o.blue = hold[7:0];
				o.alpha = alpha_on ? hpd_pkg::AlphaOn : 8'd0;
				o.last = (i + 1 == n);
				pending_pixels.push_back(o);
			end
		endfunction

		function void check_output(hpd_pkg::out_item_t got);
			hpd_pkg::out_item_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel %h", $time, got);
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			if (got !== e) begin
				$display({"%0t: pixel mismatch expected r%0d g%0d b%0d a%0d l%0d",
					" got r%0d g%0d b%0d a%0d l%0d"},
					$time, e.red, e.green, e.blue, e.alpha, e.last,
					got.red, got.green, got.blue, got.alpha, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	hpd_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	hpd_pkg::out_item_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [0:0] cfg_data;

	pixel_scoreboard sb;
	bit written [hpd_pkg::PaletteDepth];
	int in_idle_pct;
	int out_idle_pct;
	bit hold_off;

	ham_pixel_decoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("ham_pixel_decoder_tb failed");
		$finish;
	end

	// receiver
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			out_stall <= hold_off || ($urandom_range(99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_output(out_data);
	end

	// valid stays high after a transaction so that the next one can follow directly
	task automatic send(hpd_pkg::in_item_t it);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic write_palette(int idx, logic [23:0] col);
		hpd_pkg::in_item_t it;
		it = '0;
		it.op = hpd_pkg::OP_PAL_WRITE;
		it.palette_index = 6'(idx);
		it.palette_color = col;
		it.plane_bytes = {$urandom, $urandom};
		written[idx] = 1;
		send(it);
	endtask

	// only codes that load a written entry are allowed
	function automatic logic [63:0] safe_planes(logic [63:0] p, bit ham8);
		logic [7:0] code;
		int nplanes;
		nplanes = ham8 ? 8 : 6;
		for (int i = 0; i < 8; i++) begin
			code = '0;
			for (int k = 0; k < nplanes; k++) code[k] = p[8 * k + 7 - i];
			if (ham8 ? (code[7:6] == hpd_pkg::MOD_LOAD && !written[code[5:0]])
					: (code[5:4] == hpd_pkg::MOD_LOAD && !written[code[3:0]]))
				p[8 * (nplanes - 1) + 7 - i] = 1;
		end
		return p;
	endfunction

	task automatic decode(logic [63:0] p, int cnt, bit ls);
		hpd_pkg::in_item_t it;
		it.op = hpd_pkg::OP_DECODE;
		it.palette_index = 6'($urandom);
		it.palette_color = 24'($urandom);
		it.plane_bytes = safe_planes(p, sb.ham8);
		it.pixel_count = 4'(cnt);
		it.line_start = ls;
		send(it);
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		while (n < 20) begin
			@(posedge clk);
			n++;
		end
		@(negedge clk);
	endtask

	task automatic set_reg(hpd_pkg::reg_idx_t idx, bit v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
		if (idx == hpd_pkg::REG_HAM8) sb.ham8 = v;
		else sb.alpha_on = v;
	endtask

	task automatic random_decode();
		logic [63:0] p;
		p = {$urandom, $urandom};
		decode(p, ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8),
			$urandom_range(7) == 0);
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_off = 0;
		in_idle_pct = 0;
		out_idle_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed
		set_reg(hpd_pkg::REG_HAM8, 0);
		set_reg(hpd_pkg::REG_ALPHA, 1);
		write_palette(0, 24'h123456);
		write_palette(63, 24'hffffff);
		write_palette(5, 24'h000000);
		write_palette(15, 24'habcdef);
		decode(64'h0000_3f00_0000_0000, 8, 1);
		decode(64'hffff_ffff_ffff_ffff, 8, 0);
		decode(64'h0000_0000_0000_0000, 8, 1);
		decode(64'h00ff_00ff_00ff_00ff, 15, 0);
		decode(64'h0030_c0aa_55f0_0f33, 0, 1);
		decode(64'hff00_ff00_ff00_ff00, 1, 0);
		drain();
		set_reg(hpd_pkg::REG_HAM8, 1);
		set_reg(hpd_pkg::REG_ALPHA, 0);
		decode(64'h0000_0000_0000_0000, 8, 1);
		decode(64'hffff_ffff_ffff_ffff, 8, 0);
		decode(64'h40c0_aa55_0ff0_33cc, 12, 1);
		decode(64'h8000_ffff_ffff_ffff, 3, 0);
		drain();

		// random, with idling except in phase 1
		for (int ph = 0; ph < 4; ph++) begin
			set_reg(hpd_pkg::REG_HAM8, ph[0]);
			set_reg(hpd_pkg::REG_ALPHA, ph[1]);
			in_idle_pct = (ph == 1) ? 0 : 12;
			out_idle_pct = (ph == 1) ? 0 : 12;
			for (int i = 0; i < 120; i++) begin
				if ($urandom_range(9) == 0)
					write_palette($urandom_range(hpd_pkg::PaletteDepth - 1), 24'($urandom));
				else random_decode();
				if (ph == 2 && i == 40) begin
					fork
						begin
							hold_off = 1;
							repeat (200) @(posedge clk);
							hold_off = 0;
						end
						repeat (20) random_decode();
					join
				end
				if (ph == 3 && i == 60) drain();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_pixels.size() == 0)
			$display("ham_pixel_decoder_tb passed");
		else
			$display("ham_pixel_decoder_tb failed");
		$finish;
	end
endmodule

`default_nettype wire

[ham_pixel_decoder.f]
sv/hpd_pkg.sv
sv/hpd_lane.sv
sv/ham_pixel_decoder.sv
verif/ham_pixel_decoder_tb.sv
